// File: src/dbm_pkg.sv
package dbm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int VOLT_W      = 14;
    localparam int DECAY_W     = 16;
    localparam int WEIGHT_W    = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int BEEP_W      = 3;

    localparam logic [VOLT_W-1:0]   VOLT_MAX      = 14'h3FFF;
    localparam logic [DECAY_W-1:0]  DECAY_RESET   = 16'd58982;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 18'd91606;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WEIGHT  = 2'd3;

    // battery status codes
    localparam logic [1:0] STATUS_EXTERNAL = 2'd0;
    localparam logic [1:0] STATUS_GOOD     = 2'd1;
    localparam logic [1:0] STATUS_WARN     = 2'd2;
    localparam logic [1:0] STATUS_BAD      = 2'd3;

    // beep cadence
    localparam logic [BEEP_W-1:0] BEEP_ON_LIMIT = 3'd3;
    localparam logic [BEEP_W-1:0] BEEP_WRAP     = 3'd4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_one;
        logic [SAMPLE_BITS-1:0] sample_two;
        logic                   external_power;
    } t_dbm_in;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_one;
        logic [VOLT_W-1:0] voltage_two;
        logic [1:0]        battery_status;
        logic              speaker_on;
    } t_dbm_out;

endpackage

// File: src/dbm_smoother.sv
module dbm_smoother
    import dbm_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic [VOLT_W-1:0]      i_old,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [DECAY_W-1:0]     i_decay,
    input  logic [WEIGHT_W-1:0]    i_weight,
    output logic [VOLT_W-1:0]      o_new
);

    localparam int SAMPLE_W = (ADC_BITS < SAMPLE_BITS) ? ADC_BITS : SAMPLE_BITS;
    localparam int POLD_W   = VOLT_W + DECAY_W;
    localparam int PSMP_W   = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W    = ((POLD_W > PSMP_W) ? POLD_W : PSMP_W) + 1;
    localparam int SHR_W    = ACC_W - 16;

    logic [SAMPLE_W-1:0] w_sample;
    logic [POLD_W-1:0]   w_p_old;
    logic [PSMP_W-1:0]   w_p_smp;
    logic [ACC_W-1:0]    w_acc;
    logic [SHR_W-1:0]    w_shr;

    assign w_sample = i_sample[SAMPLE_W-1:0];
    assign w_p_old  = POLD_W'(i_old) * POLD_W'(i_decay);
    assign w_p_smp  = PSMP_W'(w_sample) * PSMP_W'(i_weight);
    assign w_acc    = ACC_W'(w_p_old) + ACC_W'(w_p_smp);
    assign w_shr    = w_acc[ACC_W-1:16];

    // saturate at full scale
    assign o_new = (w_shr > SHR_W'(VOLT_MAX)) ? VOLT_MAX : w_shr[VOLT_W-1:0];

endmodule

// File: src/dual_battery_monitor.sv
// dual battery monitor
// each input request carries one raw adc sample per battery and the external
// power flag; each output request carries both smoothed voltages, the pack
// status (0 external, 1 good, 2 warn, 3 bad) and the speaker level
// both channels are valid/ready; configuration is a plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data) used while the block is idle
// a request accepted passes through the input register, then the result
// register, before it shows on o_out_data
// throughput: one request per cycle while results are taken; it is set by the
// smoothing state feedback: multiply-add, shift, saturate and threshold compare
// all close combinationally from the voltage registers back to themselves
// when the receiver stalls the result register holds; the input register
// still takes one more request, then o_in_ready drops until the result drains
// reset clears both stages, both voltages, the beep counter and the speaker,
// and loads the default thresholds and smoothing weights
module dual_battery_monitor
    import dbm_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_dbm_in               i_in_data,
    // result requests
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_dbm_out              o_out_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [VOLT_W-1:0]   r_warn_th;
    logic [VOLT_W-1:0]   r_bad_th;
    logic [DECAY_W-1:0]  r_decay;
    logic [WEIGHT_W-1:0] r_weight;

    // input stage
    logic    r_in_valid;
    t_dbm_in r_in;

    // smoothing and speaker state
    logic [VOLT_W-1:0] r_volt_one;
    logic [VOLT_W-1:0] r_volt_two;
    logic [BEEP_W-1:0] r_beep;
    logic              r_spk;

    // result stage
    logic     r_out_valid;
    t_dbm_out r_out;

    logic [VOLT_W-1:0] n_volt_one;
    logic [VOLT_W-1:0] n_volt_two;
    logic [BEEP_W-1:0] n_beep;
    logic              n_spk;
    logic [1:0]        n_status;
    logic [BEEP_W-1:0] w_beep_inc;
    logic              w_adv;

    // result register free or draining this cycle
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_th <= '0;
            r_bad_th  <= '0;
            r_decay   <= DECAY_RESET;
            r_weight  <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WARN_THRESHOLD: r_warn_th <= i_cfg_data[VOLT_W-1:0];
                CFG_BAD_THRESHOLD:  r_bad_th  <= i_cfg_data[VOLT_W-1:0];
                CFG_DECAY_FACTOR:   r_decay   <= i_cfg_data[DECAY_W-1:0];
                CFG_SAMPLE_WEIGHT:  r_weight  <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // one smoother per battery
    dbm_smoother #(
        .ADC_BITS (ADC_BITS)
    ) u_smooth_one (
        .i_old    (r_volt_one),
        .i_sample (r_in.sample_one),
        .i_decay  (r_decay),
        .i_weight (r_weight),
        .o_new    (n_volt_one)
    );

    dbm_smoother #(
        .ADC_BITS (ADC_BITS)
    ) u_smooth_two (
        .i_old    (r_volt_two),
        .i_sample (r_in.sample_two),
        .i_decay  (r_decay),
        .i_weight (r_weight),
        .o_new    (n_volt_two)
    );

    assign w_beep_inc = r_beep + BEEP_W'(1);

    // status and speaker; external power leaves speaker and cadence alone
    always_comb begin
        n_beep = r_beep;
        n_spk  = r_spk;
        if (r_in.external_power) begin
            n_status = STATUS_EXTERNAL;
        end else if (n_volt_one > r_warn_th || n_volt_two > r_warn_th) begin
            n_status = STATUS_GOOD;
            n_spk    = 1'b0;
        end else if (n_volt_one > r_bad_th || n_volt_two > r_bad_th) begin
            n_status = STATUS_WARN;
            n_beep   = w_beep_inc;
            if (w_beep_inc < BEEP_ON_LIMIT) begin
                n_spk = 1'b1;
            end else if (w_beep_inc == BEEP_WRAP) begin
                // end of cadence, speaker keeps its level
                n_beep = '0;
            end else begin
                n_spk = 1'b0;
            end
        end else begin
            n_status = STATUS_BAD;
            n_spk    = !r_spk;
        end
    end

    // state and result advance together with the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_volt_one  <= '0;
            r_volt_two  <= '0;
            r_beep      <= '0;
            r_spk       <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_volt_one <= n_volt_one;
                r_volt_two <= n_volt_two;
                r_beep     <= n_beep;
                r_spk      <= n_spk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out.voltage_one    <= n_volt_one;
            r_out.voltage_two    <= n_volt_two;
            r_out.battery_status <= n_status;
            r_out.speaker_on     <= n_spk;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/dbm_checker.sv
module dbm_checker
    import dbm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     o_in_ready,
    input  logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dbm_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a good pack always silences the speaker
    a_good_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.battery_status == STATUS_GOOD
        |-> !o_out_data.speaker_on)
        else $error("speaker on with good status");

    // with the result stage empty the block always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("not ready with empty result stage");

endmodule

bind dual_battery_monitor dbm_checker u_dbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: sim/tb_dual_battery_monitor.sv
module tb_dual_battery_monitor;
    import dbm_pkg::*;

    // sample width used by the block under test
    localparam int ADC_BITS     = 10;
    // accept edge to result edge, plus a margin
    localparam int LATENCY      = 2;
    // cycles with no request moving on either channel before the run gives up
    localparam int IDLE_LIMIT   = 5000;
    // long receiver hold-off that fills the block and stalls its input
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 500;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_dbm_in               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_dbm_out              o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dual_battery_monitor #(.ADC_BITS(ADC_BITS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the register file
    logic [VOLT_W-1:0]   warn_level;
    logic [VOLT_W-1:0]   bad_level;
    logic [DECAY_W-1:0]  decay_gain;
    logic [WEIGHT_W-1:0] sample_gain;

    // shadow copy of the monitor state
    logic [VOLT_W-1:0]   volt_one_acc;
    logic [VOLT_W-1:0]   volt_two_acc;
    logic [BEEP_W-1:0]   beep_phase;
    logic                speaker_state;

    // predicted results, oldest first
    t_dbm_out pending_results[$];
    t_dbm_out oldest_result;

    int error_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int settings_used   = 0;
    int in_stall_cycles = 0;
    int status_seen[4]  = '{default: 0};

    // sender pacing: bursts of requests separated by gaps
    bit tx_bursty     = 1'b0;
    int tx_burst_left = 0;

    // receiver pacing: mode, rotating stall pattern, long hold-off counter
    t_rx_mode    rx_mode      = RX_ALWAYS;
    logic [7:0]  rx_pattern   = 8'hFF;
    int          rx_tick      = 0;
    int          rx_hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // monitor prediction
    // ---------------------------------------------------------------

    function automatic void reset_monitor_model();
        warn_level    = '0;
        bad_level     = '0;
        decay_gain    = DECAY_RESET;
        sample_gain   = WEIGHT_RESET;
        volt_one_acc  = '0;
        volt_two_acc  = '0;
        beep_phase    = '0;
        speaker_state = 1'b0;
    endfunction

    // exponential smoothing in q16: exact 64 bit products, floor, saturate
    function automatic logic [VOLT_W-1:0] smooth_voltage(input logic [VOLT_W-1:0] old_volt,
                                                         input logic [SAMPLE_BITS-1:0] raw);
        logic [63:0] adc_value;
        logic [63:0] acc;
        adc_value = 64'(raw) & ((64'd1 << ADC_BITS) - 64'd1);
        acc = 64'(old_volt) * 64'(decay_gain) + adc_value * 64'(sample_gain);
        acc = acc >> 16;
        if (acc > 64'(VOLT_MAX))
            return VOLT_MAX;
        return acc[VOLT_W-1:0];
    endfunction

    // advance the shadow state by one reading and return the result it causes
    function automatic t_dbm_out step_monitor_model(input t_dbm_in reading);
        t_dbm_out   res;
        logic [1:0] status;
        volt_one_acc = smooth_voltage(volt_one_acc, reading.sample_one);
        volt_two_acc = smooth_voltage(volt_two_acc, reading.sample_two);
        if (reading.external_power) begin
            // speaker and cadence frozen while on external supply
            status = STATUS_EXTERNAL;
        end else if (volt_one_acc > warn_level || volt_two_acc > warn_level) begin
            status        = STATUS_GOOD;
            speaker_state = 1'b0;
        end else if (volt_one_acc > bad_level || volt_two_acc > bad_level) begin
            status     = STATUS_WARN;
            beep_phase = beep_phase + 1'b1;
            if (beep_phase < BEEP_ON_LIMIT) begin
                speaker_state = 1'b1;
            end else if (beep_phase == BEEP_WRAP) begin
                // cadence restarts, speaker keeps its level
                beep_phase = '0;
            end else begin
                speaker_state = 1'b0;
            end
        end else begin
            status        = STATUS_BAD;
            speaker_state = ~speaker_state;
        end
        res.voltage_one    = volt_one_acc;
        res.voltage_two    = volt_two_acc;
        res.battery_status = status;
        res.speaker_on     = speaker_state;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking and receiver pacing
    // ---------------------------------------------------------------

    function automatic void compare_field(input string field_name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        // values read here are the ones present just before this edge
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result request with nothing outstanding: %p", o_out_data);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                compare_field("voltage_one", oldest_result.voltage_one,
                              o_out_data.voltage_one);
                compare_field("voltage_two", oldest_result.voltage_two,
                              o_out_data.voltage_two);
                compare_field("battery_status", oldest_result.battery_status,
                              o_out_data.battery_status);
                compare_field("speaker_on", oldest_result.speaker_on,
                              o_out_data.speaker_on);
                status_seen[oldest_result.battery_status]++;
                results_checked++;
            end
        end
        if (i_rst_n && i_in_valid && !o_in_ready)
            in_stall_cycles++;

        // next ready level: long hold-off first, else the phase's stall mode
        rx_tick++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_out_ready <= 1'b1;
                RX_RANDOM:  i_out_ready <= ($urandom_range(0, 99) < 60);
                default:    i_out_ready <= rx_pattern[rx_tick % 8];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // watchdog: ends the run if requests stop moving
    // ---------------------------------------------------------------

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request moved for %0d cycles, %0d results still due",
                 IDLE_LIMIT, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // offer one reading, hold it until taken, then record its prediction
    task automatic send_reading(input t_dbm_in reading);
        int gap;
        if (tx_bursty) begin
            if (tx_burst_left == 0) begin
                gap           = $urandom_range(1, 6);
                tx_burst_left = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            tx_burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_data  <= reading;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(step_monitor_model(reading));
        items_sent++;
    endtask

    // stop offering, let every outstanding result drain, then settle
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            CFG_WARN_THRESHOLD: warn_level  = data[VOLT_W-1:0];
            CFG_BAD_THRESHOLD:  bad_level   = data[VOLT_W-1:0];
            CFG_DECAY_FACTOR:   decay_gain  = data[DECAY_W-1:0];
            CFG_SAMPLE_WEIGHT:  sample_gain = data[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // new setting for all four registers, only while the block is idle
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] warn_data,
                                  input logic [CFG_DATA_W-1:0] bad_data,
                                  input logic [CFG_DATA_W-1:0] decay_data,
                                  input logic [CFG_DATA_W-1:0] weight_data);
        wait_until_drained();
        write_register(CFG_WARN_THRESHOLD, warn_data);
        write_register(CFG_BAD_THRESHOLD, bad_data);
        write_register(CFG_DECAY_FACTOR, decay_data);
        write_register(CFG_SAMPLE_WEIGHT, weight_data);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random garbage above a register's width, the block must drop it
    function automatic logic [CFG_DATA_W-1:0] junk_above(input logic [CFG_DATA_W-1:0] value,
                                                         input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = '1;
        keep = keep >> (CFG_DATA_W - width);
        return (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] raw_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_dbm_in make_reading(input int one, input int two, input bit ext);
        t_dbm_in reading;
        reading.sample_one     = SAMPLE_BITS'(one);
        reading.sample_two     = SAMPLE_BITS'(two);
        reading.external_power = ext;
        return reading;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset thresholds of zero and default smoothing, field extremes
    task automatic test_reset_values();
        send_reading(make_reading(0, 0, 0));
        send_reading(make_reading(1023, 1023, 0));
        send_reading(make_reading(1023, 0, 1));
        send_reading(make_reading(0, 1023, 0));
    endtask

    // pass-through smoothing so samples land directly in each band
    task automatic test_status_cadence();
        apply_settings(600, 300, 0, 18'h10000);
        // warn band: on, on, off, wrap keeps level, then on again
        repeat (6) send_reading(make_reading(450, 200, 0));
        send_reading(make_reading(100, 800, 0));
        repeat (2) send_reading(make_reading(100, 100, 0));
        // external supply freezes speaker and cadence
        send_reading(make_reading(450, 450, 1));
        send_reading(make_reading(0, 400, 0));
    endtask

    // warn threshold below bad threshold, junk above register widths
    task automatic test_threshold_order();
        apply_settings(18'h3C064, 18'h3C384, 18'h30000, 18'h10000);
        send_reading(make_reading(500, 500, 0));
        send_reading(make_reading(50, 50, 0));
        send_reading(make_reading(100, 0, 0));
        send_reading(make_reading(0, 101, 0));
    endtask

    // largest gains drive both voltages into saturation, then zero gains
    task automatic test_saturation();
        apply_settings(CFG_DATA_W'(VOLT_MAX), CFG_DATA_W'(VOLT_MAX), 18'h0FFFF, 18'h3FFFF);
        repeat (5) send_reading(make_reading(1023, 1023, 0));
        apply_settings(0, 0, 0, 0);
        send_reading(make_reading(1023, 1023, 0));
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        apply_settings(600, 300, 0, 18'h10000);
        tx_bursty    = 1'b0;
        rx_mode      = RX_ALWAYS;
        rx_hold_left = HOLD_CYCLES;
        repeat (24) send_reading(make_reading(int'(raw_sample()), int'(raw_sample()),
                                              1'($urandom_range(0, 1))));
    endtask

    // phases of random settings; mostly steady runs that sit in one band
    task automatic test_random_traffic();
        int target;
        int kind;
        int phase_left;
        int base;
        int hi;
        t_dbm_in reading;
        logic [VOLT_W-1:0]   warn_pick;
        logic [VOLT_W-1:0]   bad_pick;
        logic [DECAY_W-1:0]  decay_pick;
        logic [WEIGHT_W-1:0] weight_pick;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: begin
                    // pass-through smoothing, thresholds in sample range
                    decay_pick  = '0;
                    weight_pick = 18'h10000;
                    warn_pick   = VOLT_W'($urandom_range(0, 1023));
                    bad_pick    = VOLT_W'($urandom_range(0, 1023));
                end
                1: begin
                    decay_pick  = DECAY_W'($urandom);
                    weight_pick = WEIGHT_W'($urandom);
                    warn_pick   = VOLT_W'($urandom);
                    bad_pick    = VOLT_W'($urandom);
                end
                2: begin
                    // default smoothing settles near 14 times the sample
                    decay_pick  = DECAY_RESET;
                    weight_pick = WEIGHT_RESET;
                    warn_pick   = VOLT_W'($urandom_range(0, 14500));
                    bad_pick    = VOLT_W'($urandom_range(0, 14500));
                end
                default: begin
                    decay_pick  = $urandom_range(0, 1) ? '1 : '0;
                    weight_pick = $urandom_range(0, 1) ? '1 : '0;
                    warn_pick   = $urandom_range(0, 1) ? VOLT_MAX : '0;
                    bad_pick    = $urandom_range(0, 1) ? VOLT_MAX : '0;
                end
            endcase
            apply_settings(junk_above(CFG_DATA_W'(warn_pick), VOLT_W),
                           junk_above(CFG_DATA_W'(bad_pick), VOLT_W),
                           junk_above(CFG_DATA_W'(decay_pick), DECAY_W), weight_pick);
            tx_bursty  = ($urandom_range(0, 2) != 0);
            rx_mode    = t_rx_mode'($urandom_range(0, 2));
            rx_pattern = 8'($urandom) | 8'h01;
            phase_left = $urandom_range(30, 70);
            while (phase_left > 0 && items_sent < target) begin
                if ($urandom_range(0, 9) < 7) begin
                    // steady run: the larger sample stays at one level
                    hi = (warn_pick > 1023) ? 1023 : warn_pick;
                    if (kind == 0 && bad_pick < hi)
                        base = $urandom_range(bad_pick + 1, hi);
                    else
                        base = $urandom_range(0, 1023);
                    repeat ($urandom_range(3, 10)) begin
                        reading = make_reading(base, $urandom_range(0, base),
                                               $urandom_range(0, 9) == 0);
                        if ($urandom_range(0, 1))
                            {reading.sample_one, reading.sample_two} =
                                {reading.sample_two, reading.sample_one};
                        send_reading(reading);
                        phase_left--;
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_reading(make_reading(int'(raw_sample()), int'(raw_sample()),
                                                  1'($urandom_range(0, 1))));
                        phase_left--;
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_WARN_THRESHOLD;
        i_cfg_data  <= '0;
        reset_monitor_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with light pacing on both sides
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        test_reset_values();
        test_status_cadence();
        test_threshold_order();
        test_saturation();
        test_backpressure();
        test_random_traffic();
        wait_until_drained();

        $display("checked %0d results from %0d requests over %0d register settings",
                 results_checked, items_sent, settings_used);
        $display("status mix ext/good/warn/bad %0d/%0d/%0d/%0d, input stalled %0d cycles",
                 status_seen[STATUS_EXTERNAL], status_seen[STATUS_GOOD],
                 status_seen[STATUS_WARN], status_seen[STATUS_BAD], in_stall_cycles);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: dual_battery_monitor.f
src/dbm_pkg.sv
src/dbm_smoother.sv
src/dual_battery_monitor.sv
src/dbm_checker.sv
sim/tb_dual_battery_monitor.sv
